// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the conv/pool stream block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define CVMP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication check.
`define CVMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

// ----- hw/rtl/cvmp_pkg.sv -----
// Shared constants, types and helper functions of the conv/pool stream block.
package cvmp_pkg;

   localparam int IMAGE_SIZE = 28;
   localparam int HALF_SIZE  = IMAGE_SIZE / 2;
   localparam int COL_W      = $clog2(IMAGE_SIZE);
   localparam int HALF_W     = COL_W - 1;
   localparam int CNT_W      = $clog2(IMAGE_SIZE + 1);

   localparam int PIX_W      = 8;
   localparam int TAP_W      = 8;
   localparam int BIAS_W     = 16;
   localparam int PROD_W     = 16;
   localparam int ROWSUM_W   = 18;
   localparam int ACC_W      = 20;
   localparam int NUM_TAPS   = 9;
   localparam int IDX_W      = 4;
   localparam int POOL_W     = 2 * PIX_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KERNEL0  = 3'd0,
      CSR_KERNEL1  = 3'd1,
      CSR_LAST     = 3'd2,
      CSR_BIAS0    = 3'd3,
      CSR_BIAS1    = 3'd4
   } csr_idx_type;

   typedef logic signed [TAP_W-1:0] tap_type;

   typedef struct packed {
      logic [NUM_TAPS-1:0][TAP_W-1:0] taps0;
      logic [NUM_TAPS-1:0][TAP_W-1:0] taps1;
      logic [BIAS_W-1:0]              bias0;
      logic [BIAS_W-1:0]              bias1;
   } coef_type;

   // one row pass for the back end
   typedef struct packed {
      logic [COL_W-1:0] row;     // conv row to compute
      logic [1:0]       slot;    // line slot holding that row
      logic             emit;    // burst pooled row after the pass
      logic             second;  // follow with a pass of the next row
   } row_job_type;

   typedef struct packed {
      logic             en;
      logic [1:0]       slot;
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] data;
   } line_wr_type;

   function automatic logic [1:0] slot_next(input logic [1:0] s);
      return (s == 2'd2) ? 2'd0 : s + 2'd1;
   endfunction

   function automatic logic [1:0] slot_prev(input logic [1:0] s);
      return (s == 2'd0) ? 2'd2 : s - 2'd1;
   endfunction

   function automatic logic signed [PROD_W-1:0] mul_px(input logic [PIX_W-1:0] p,
                                                       input tap_type t);
      logic signed [PIX_W+TAP_W:0] full;
      full = $signed({1'b0, p}) * t;
      return full[PROD_W-1:0];
   endfunction

   function automatic logic [PIX_W-1:0] clamp_px(input logic signed [ACC_W-1:0] a);
      logic [PIX_W-1:0] r;
      if (a < 0) begin
         r = '0;
      end else if (a > 255) begin
         r = PIX_MAX;
      end else begin
         r = a[PIX_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [PIX_W-1:0] max_px(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [IDX_W-1:0] idx_row(input logic [COL_W-1:0] y);
      logic [COL_W+IDX_W-1:0] ext;
      ext = {{IDX_W{1'b0}}, y};
      return ext[IDX_W:1];
   endfunction

   function automatic logic [IDX_W-1:0] idx_col(input logic [HALF_W-1:0] p);
      logic [HALF_W+IDX_W-1:0] ext;
      ext = {{IDX_W{1'b0}}, p};
      return ext[IDX_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/cvmp_if.sv -----
// Stream and register-write channel interfaces of the conv/pool block.
interface cvmp_req_if;
   import cvmp_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

interface cvmp_rsp_if;
   import cvmp_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] feature_a;
   logic [PIX_W-1:0] feature_b;
   logic [IDX_W-1:0] pooled_row;
   logic [IDX_W-1:0] pooled_col;
   logic             row_end;
   logic             image_end;
   modport source (output valid, output feature_a, output feature_b, output pooled_row,
                   output pooled_col, output row_end, output image_end, input ready);
   modport sink (input valid, input feature_a, input feature_b, input pooled_row,
                 input pooled_col, input row_end, input image_end, output ready);
endinterface

interface cvmp_csr_if;
   import cvmp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/cvmp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cvmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/cvmp_front.sv -----
// Front end: takes pixels, tracks raster position, writes lines, queues row passes.
`include "assert_macros.svh"
module cvmp_front (
   input  logic                   clock,
   input  logic                   reset,
   cvmp_req_if.sink               req_chan,
   input  logic                   q_empty,
   input  logic                   lines_free,
   output logic                   push,
   output cvmp_pkg::row_job_type  push_job,
   output cvmp_pkg::line_wr_type  line_wr
);
   import cvmp_pkg::*;

   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] row_ff, row_in;
   logic [1:0]       slot_ff, slot_in;
   logic             acc;
   logic             row_done;
   logic             last_row;

   assign req_chan.ready = q_empty && lines_free;
   assign acc      = req_chan.valid && req_chan.ready;
   assign row_done = (col_ff == COL_W'(IMAGE_SIZE - 1));
   assign last_row = (row_ff == COL_W'(IMAGE_SIZE - 1));

   assign line_wr.en   = acc;
   assign line_wr.slot = slot_ff;
   assign line_wr.col  = col_ff;
   assign line_wr.data = req_chan.pixel;

   // row r done: compute conv row r-1, burst if it is odd; last row adds row r
   assign push            = acc && row_done && (row_ff != '0);
   assign push_job.row    = row_ff - COL_W'(1);
   assign push_job.slot   = slot_prev(slot_ff);
   assign push_job.emit   = !row_ff[0];
   assign push_job.second = last_row;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (acc) begin
         if (row_done) begin
            col_in = '0;
            if (last_row) begin
               row_in  = '0;
               slot_in = 2'd0;
            end else begin
               row_in  = row_ff + COL_W'(1);
               slot_in = slot_next(slot_ff);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= 2'd0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   `CVMP_ASSERT_NEXT(a_stall_after_push, clock, reset, push, !req_chan.ready)
endmodule

// ----- hw/rtl/cvmp_job_fifo.sv -----
// Two-entry queue of row passes between front and back end.
`include "assert_macros.svh"
module cvmp_job_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cvmp_pkg::row_job_type push_job,
   input  logic                  pop,
   output logic                  empty,
   output cvmp_pkg::row_job_type head
);
   import cvmp_pkg::*;

   row_job_type slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;

   assign empty = (cnt_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   `CVMP_ASSERT_IMPLY(a_no_overflow, clock, reset, push, cnt_ff != 2'd2)
   `CVMP_ASSERT_IMPLY(a_no_underflow, clock, reset, pop, cnt_ff != 2'd0)
endmodule

// ----- hw/rtl/cvmp_back.sv -----
// Back end: per-row conv/clamp/pool pass through a 4-stage pipe, then pooled burst.
`include "assert_macros.svh"
module cvmp_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cvmp_pkg::coef_type                   coef,
   input  logic                                 q_empty,
   input  cvmp_pkg::row_job_type                q_head,
   output logic                                 q_pop,
   output logic                                 lines_free,
   output logic                                 line_rd_en,
   output logic [cvmp_pkg::COL_W-1:0]           line_rd_col,
   input  logic [2:0][cvmp_pkg::PIX_W-1:0]      line_rd_data,
   cvmp_rsp_if.source                           rsp_chan
);
   import cvmp_pkg::*;

   typedef enum logic [3:0] {
      B_IDLE    = 4'b0001,
      B_CONV    = 4'b0010,
      B_EMIT_RD = 4'b0100,
      B_EMIT_LD = 4'b1000
   } back_state_type;

   back_state_type st_ff, st_in;
   row_job_type    job_ff, job_in, start_job;
   logic           start;

   logic [CNT_W-1:0] rdc_ff, rdc_in;
   logic             issue_ff, issue_in;

   logic             v1_ff;
   logic [CNT_W-1:0] c1_ff;
   logic             pad, top_zero, bot_zero;
   logic [2:0][PIX_W-1:0]       new_col;
   logic [2:0][2:0][PIX_W-1:0]  win_ff;   // [column][row]
   logic [2:0][2:0][PIX_W-1:0]  win_nx;

   logic                       va_ff, vb_ff, vc_ff;
   logic [COL_W-1:0]           xa_ff, xb_ff, xc_ff;
   logic signed [PROD_W-1:0]   prod_ff [2][NUM_TAPS];
   logic signed [ROWSUM_W-1:0] rs_ff [2][3];
   logic signed [ACC_W-1:0]    acc_ff [2];

   logic [1:0][PIX_W-1:0] clamp_v, hold_ff, hmax, pmax;
   logic                  pass_end;

   logic                 pool_wr_en, pool_rd_en;
   logic [HALF_W-1:0]    pool_wr_addr, pool_rd_addr;
   logic [POOL_W-1:0]    pool_wr_data, pool_rd_data;

   logic [HALF_W-1:0] epx_ff, epx_in;
   logic              load;
   logic              rsp_v_ff, rsp_v_in;
   logic [PIX_W-1:0]  fa_ff, fb_ff;
   logic [IDX_W-1:0]  prow_ff, pcol_ff;
   logic              rend_ff, iend_ff;

   assign lines_free = (st_ff != B_CONV);

   // ---- column fetch and 3x3 window ----
   assign line_rd_en  = issue_ff;
   assign line_rd_col = rdc_ff[COL_W-1:0];

   assign pad      = (c1_ff == CNT_W'(IMAGE_SIZE));
   assign top_zero = pad || (job_ff.row == '0);
   assign bot_zero = pad || (job_ff.row == COL_W'(IMAGE_SIZE - 1));

   always_comb begin
      new_col[0] = top_zero ? '0 : line_rd_data[slot_prev(job_ff.slot)];
      new_col[1] = pad ? '0 : line_rd_data[job_ff.slot];
      new_col[2] = bot_zero ? '0 : line_rd_data[slot_next(job_ff.slot)];
      win_nx[0]  = win_ff[1];
      win_nx[1]  = win_ff[2];
      win_nx[2]  = new_col;
   end

   // ---- clamp and 2x2 max ----
   always_comb begin
      for (int f = 0; f < 2; f++) begin
         clamp_v[f] = clamp_px(acc_ff[f]);
         hmax[f]    = max_px(hold_ff[f], clamp_v[f]);
         pmax[f]    = max_px(hmax[f], pool_rd_data[f*PIX_W +: PIX_W]);
      end
   end

   assign pass_end     = vc_ff && (xc_ff == COL_W'(IMAGE_SIZE - 1));
   assign pool_wr_en   = vc_ff && xc_ff[0];
   assign pool_wr_addr = xc_ff[COL_W-1:1];
   assign pool_wr_data = job_ff.row[0] ? pmax : hmax;
   assign pool_rd_en   = (vc_ff && !xc_ff[0]) || (st_ff == B_EMIT_RD);
   assign pool_rd_addr = (st_ff == B_EMIT_RD) ? epx_ff : xc_ff[COL_W-1:1];

   cvmp_ram #(.WIDTH(POOL_W), .DEPTH(HALF_SIZE)) u_pool_ram (
      .clock   (clock),
      .wr_en   (pool_wr_en),
      .wr_addr (pool_wr_addr),
      .wr_data (pool_wr_data),
      .rd_en   (pool_rd_en),
      .rd_addr (pool_rd_addr),
      .rd_data (pool_rd_data)
   );

   // ---- sequencer ----
   always_comb begin
      st_in     = st_ff;
      job_in    = job_ff;
      start     = 1'b0;
      start_job = q_head;
      q_pop     = 1'b0;
      epx_in    = epx_ff;
      load      = 1'b0;
      unique case (st_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               start = 1'b1;
               st_in = B_CONV;
            end
         end
         B_CONV: begin
            if (pass_end) begin
               priority if (job_ff.emit) begin
                  st_in  = B_EMIT_RD;
                  epx_in = '0;
               end else if (job_ff.second) begin
                  start            = 1'b1;
                  start_job.row    = job_ff.row + COL_W'(1);
                  start_job.slot   = slot_next(job_ff.slot);
                  start_job.emit   = 1'b1;
                  start_job.second = 1'b0;
               end else begin
                  st_in = B_IDLE;
               end
            end
         end
         B_EMIT_RD: begin
            st_in = B_EMIT_LD;
         end
         B_EMIT_LD: begin
            if (!rsp_v_ff || rsp_chan.ready) begin
               load = 1'b1;
               if (epx_ff == HALF_W'(HALF_SIZE - 1)) begin
                  st_in = B_IDLE;
               end else begin
                  epx_in = epx_ff + HALF_W'(1);
                  st_in  = B_EMIT_RD;
               end
            end
         end
         default: begin
            st_in = B_IDLE;
         end
      endcase
      if (start) begin
         job_in = start_job;
      end
   end

   always_comb begin
      rdc_in   = rdc_ff;
      issue_in = issue_ff;
      if (start) begin
         rdc_in   = '0;
         issue_in = 1'b1;
      end else if (issue_ff) begin
         rdc_in   = rdc_ff + CNT_W'(1);
         issue_in = (rdc_ff != CNT_W'(IMAGE_SIZE));
      end
      rsp_v_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= B_IDLE;
         issue_ff <= 1'b0;
         rdc_ff   <= '0;
         v1_ff    <= 1'b0;
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
         vc_ff    <= 1'b0;
         epx_ff   <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         issue_ff <= issue_in;
         rdc_ff   <= rdc_in;
         v1_ff    <= issue_ff;
         va_ff    <= v1_ff && (c1_ff != '0);
         vb_ff    <= va_ff;
         vc_ff    <= vb_ff;
         epx_ff   <= epx_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      c1_ff  <= rdc_ff;
      if (start) begin
         win_ff <= '0;
      end else if (v1_ff) begin
         win_ff <= win_nx;
      end
      xa_ff <= COL_W'(c1_ff - CNT_W'(1));
      for (int ky = 0; ky < 3; ky++) begin
         for (int kx = 0; kx < 3; kx++) begin
            prod_ff[0][ky*3+kx] <= mul_px(win_nx[kx][ky], coef.taps0[ky*3+kx]);
            prod_ff[1][ky*3+kx] <= mul_px(win_nx[kx][ky], coef.taps1[ky*3+kx]);
         end
      end
      xb_ff <= xa_ff;
      for (int f = 0; f < 2; f++) begin
         for (int ky = 0; ky < 3; ky++) begin
            rs_ff[f][ky] <= ROWSUM_W'(prod_ff[f][ky*3]) + ROWSUM_W'(prod_ff[f][ky*3+1])
                          + ROWSUM_W'(prod_ff[f][ky*3+2]);
         end
      end
      xc_ff <= xb_ff;
      acc_ff[0] <= ACC_W'(rs_ff[0][0]) + ACC_W'(rs_ff[0][1]) + ACC_W'(rs_ff[0][2])
                 + ACC_W'($signed(coef.bias0));
      acc_ff[1] <= ACC_W'(rs_ff[1][0]) + ACC_W'(rs_ff[1][1]) + ACC_W'(rs_ff[1][2])
                 + ACC_W'($signed(coef.bias1));
      if (vc_ff && !xc_ff[0]) begin
         hold_ff <= clamp_v;
      end
      if (load) begin
         fa_ff   <= pool_rd_data[PIX_W-1:0];
         fb_ff   <= pool_rd_data[POOL_W-1:PIX_W];
         prow_ff <= idx_row(job_ff.row);
         pcol_ff <= idx_col(epx_ff);
         rend_ff <= (epx_ff == HALF_W'(HALF_SIZE - 1));
         iend_ff <= (epx_ff == HALF_W'(HALF_SIZE - 1))
                 && (job_ff.row == COL_W'(IMAGE_SIZE - 1));
      end
   end

   assign rsp_chan.valid      = rsp_v_ff;
   assign rsp_chan.feature_a  = fa_ff;
   assign rsp_chan.feature_b  = fb_ff;
   assign rsp_chan.pooled_row = prow_ff;
   assign rsp_chan.pooled_col = pcol_ff;
   assign rsp_chan.row_end    = rend_ff;
   assign rsp_chan.image_end  = iend_ff;

   `CVMP_ASSERT_IMPLY(a_idle_quiet, clock, reset, st_ff == B_IDLE,
                      !(issue_ff || v1_ff || va_ff || vb_ff || vc_ff))
endmodule

// ----- hw/rtl/conv3x3_relu_maxpool_stream_unit.sv -----
// Top level of the 3x3 conv, clamp and 2x2 max-pool pixel stream unit.
//
// Takes IMAGE_SIZE x IMAGE_SIZE 8-bit images in raster order, one pixel word
// per cycle, images back to back. Two signed 3x3 kernels with zero padding and
// 16-bit biases run over each pixel; the sums are clamped to 0..255 and
// max-pooled 2x2. After input rows 2,4,..,IMAGE_SIZE-2 and the final row a
// burst of IMAGE_SIZE/2 pooled words goes out, the last flagged by row_end
// (and image_end on the final burst). Inside a row the input runs at one word
// per cycle. At the end of every row from row 1 on, input stalls while an
// earlier pooled burst drains and for one row pass of the back end (two after
// the final row): IMAGE_SIZE+1 column reads of the three line RAMs feed a
// 4-stage multiply/sum/bias/pool pipe. A burst drains from the pool RAM read
// port, one read and one load state per word, as the next row flows in. Kernel
// and bias registers are written through the csr channel (always ready); the
// user must write them only while idle, which the block does not enforce.
// They reset to zero. Line and pool RAMs need no clearing after reset.
module conv3x3_relu_maxpool_stream_unit (
   input logic        clock,
   input logic        reset,
   cvmp_req_if.sink   req_chan,
   cvmp_rsp_if.source rsp_chan,
   cvmp_csr_if.sink   csr_chan
);
   import cvmp_pkg::*;

   logic [CSR_DATA_W-1:0] k0_ff, k1_ff;
   logic [2*TAP_W-1:0]    last_ff;
   logic [BIAS_W-1:0]     b0_ff, b1_ff;
   logic                  csr_wr;
   coef_type              coef;

   logic                  q_empty, q_pop, push, lines_free;
   row_job_type           push_job, q_head;
   line_wr_type           line_wr;
   logic                  line_rd_en;
   logic [COL_W-1:0]      line_rd_col;
   logic [2:0][PIX_W-1:0] line_rd_data;

   // register file
   assign csr_chan.ready = 1'b1;
   assign csr_wr         = csr_chan.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         k0_ff   <= '0;
         k1_ff   <= '0;
         last_ff <= '0;
         b0_ff   <= '0;
         b1_ff   <= '0;
      end else if (csr_wr) begin
         if (csr_chan.index == CSR_KERNEL0) begin
            k0_ff <= csr_chan.data;
         end
         if (csr_chan.index == CSR_KERNEL1) begin
            k1_ff <= csr_chan.data;
         end
         if (csr_chan.index == CSR_LAST) begin
            last_ff <= csr_chan.data[2*TAP_W-1:0];
         end
         if (csr_chan.index == CSR_BIAS0) begin
            b0_ff <= csr_chan.data[BIAS_W-1:0];
         end
         if (csr_chan.index == CSR_BIAS1) begin
            b1_ff <= csr_chan.data[BIAS_W-1:0];
         end
      end
   end

   // unpack taps: tap 8 of both filters lives in the last-taps register
   always_comb begin
      for (int t = 0; t < NUM_TAPS - 1; t++) begin
         coef.taps0[t] = k0_ff[t*TAP_W +: TAP_W];
         coef.taps1[t] = k1_ff[t*TAP_W +: TAP_W];
      end
      coef.taps0[NUM_TAPS-1] = last_ff[TAP_W-1:0];
      coef.taps1[NUM_TAPS-1] = last_ff[2*TAP_W-1:TAP_W];
      coef.bias0 = b0_ff;
      coef.bias1 = b1_ff;
   end

   cvmp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .q_empty    (q_empty),
      .lines_free (lines_free),
      .push       (push),
      .push_job   (push_job),
      .line_wr    (line_wr)
   );

   cvmp_job_fifo u_job_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   // three line RAMs, one per row slot (row mod 3)
   for (genvar i = 0; i < 3; i++) begin : g_line
      cvmp_ram #(.WIDTH(PIX_W), .DEPTH(IMAGE_SIZE)) u_line_ram (
         .clock   (clock),
         .wr_en   (line_wr.en && (line_wr.slot == 2'(i))),
         .wr_addr (line_wr.col),
         .wr_data (line_wr.data),
         .rd_en   (line_rd_en),
         .rd_addr (line_rd_col),
         .rd_data (line_rd_data[i])
      );
   end

   cvmp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .coef         (coef),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .lines_free   (lines_free),
      .line_rd_en   (line_rd_en),
      .line_rd_col  (line_rd_col),
      .line_rd_data (line_rd_data),
      .rsp_chan     (rsp_chan)
   );
endmodule

// ----- sim/tb_top.sv -----
// Testbench for the 3x3 conv, clamp and 2x2 max-pool pixel stream unit.
`timescale 1ns / 100ps

module tb_top;
   import cvmp_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] feature_a;
      logic [PIX_W-1:0] feature_b;
      logic [IDX_W-1:0] pooled_row;
      logic [IDX_W-1:0] pooled_col;
      logic             row_end;
      logic             image_end;
   } pooled_word_type;

   typedef enum int {
      PAT_RANDOM,
      PAT_FLAT,
      PAT_CHECKER
   } pattern_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DIRECTED_WORDS = 2 * IMAGE_SIZE;
   localparam int RANDOM_WORDS   = 46;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   cvmp_req_if req_chan ();
   cvmp_rsp_if rsp_chan ();
   cvmp_csr_if csr_chan ();

   conv3x3_relu_maxpool_stream_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   // Predictor state: coefficients, three-row line store, pool scratch, position.
   logic [63:0]      coef_k0, coef_k1;
   logic [15:0]      coef_last, coef_b0, coef_b1;
   logic [PIX_W-1:0] line_mem [3*IMAGE_SIZE];
   logic [15:0]      even_max [HALF_SIZE];
   logic [15:0]      pool_pair [HALF_SIZE];
   int               cur_row, cur_col;

   pooled_word_type pooled_expect [$];
   int  error_count = 0;
   int  words_sent = 0;
   int  words_checked = 0;
   int  rows_done = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  idle_cycles = 0;

   function automatic int tap_of(int f, int t);
      logic [7:0] b;
      if (t < 8) b = f ? coef_k1[8*t +: 8] : coef_k0[8*t +: 8];
      else b = coef_last[8*f +: 8];
      return int'($signed(b));
   endfunction

   function automatic int pixel_at(int y, int x);
      if (y < 0 || y >= IMAGE_SIZE || x < 0 || x >= IMAGE_SIZE) return 0;
      return int'(line_mem[(y % 3) * IMAGE_SIZE + x]);
   endfunction

   function automatic int conv_clamped(int f, int y, int x);
      int acc;
      acc = f ? int'($signed(coef_b1)) : int'($signed(coef_b0));
      for (int ky = 0; ky < 3; ky++)
         for (int kx = 0; kx < 3; kx++)
            acc += pixel_at(y + ky - 1, x + kx - 1) * tap_of(f, ky * 3 + kx);
      if (acc < 0) return 0;
      if (acc > 255) return 255;
      return acc;
   endfunction

   function automatic void pool_conv_row(int y);
      int h [2];
      int v, p;
      for (int px = 0; px < HALF_SIZE; px++) begin
         h[0] = 0;
         h[1] = 0;
         for (int dx = 0; dx < 2; dx++)
            for (int f = 0; f < 2; f++) begin
               v = conv_clamped(f, y, px * 2 + dx);
               if (v > h[f]) h[f] = v;
            end
         if ((y & 1) == 0) begin
            even_max[px] = {h[1][7:0], h[0][7:0]};
         end else begin
            p = even_max[px][7:0];
            if (p > h[0]) h[0] = p;
            p = even_max[px][15:8];
            if (p > h[1]) h[1] = p;
            pool_pair[px] = {h[1][7:0], h[0][7:0]};
         end
      end
   endfunction

   function automatic void queue_pooled_row(int y, bit last_row);
      pooled_word_type w;
      for (int px = 0; px < HALF_SIZE; px++) begin
         w.feature_a  = pool_pair[px][7:0];
         w.feature_b  = pool_pair[px][15:8];
         w.pooled_row = IDX_W'(y / 2);
         w.pooled_col = IDX_W'(px);
         w.row_end    = (px == HALF_SIZE - 1);
         w.image_end  = (px == HALF_SIZE - 1) && last_row;
         pooled_expect.push_back(w);
      end
   endfunction

   // Advance the predictor by one accepted pixel word.
   function automatic void predict_pixel(logic [PIX_W-1:0] pix);
      int r;
      line_mem[(cur_row % 3) * IMAGE_SIZE + cur_col] = pix;
      cur_col++;
      if (cur_col < IMAGE_SIZE) return;
      cur_col = 0;
      rows_done++;
      r = cur_row;
      if (r >= 1) begin
         pool_conv_row(r - 1);
         if ((r & 1) == 0) queue_pooled_row(r - 1, 1'b0);
      end
      if (r == IMAGE_SIZE - 1) begin
         pool_conv_row(r);
         queue_pooled_row(r, 1'b1);
         cur_row = 0;
      end else begin
         cur_row = r + 1;
      end
   endfunction

   // Input drive: inputs change at the falling edge. valid stays high between
   // back-to-back words; send_words drops it after its last word.
   task automatic send_pixel(logic [PIX_W-1:0] pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pixel <= pix;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_pixel(pix);
      words_sent++;
      @(negedge clock);
   endtask

   // valid stays high across a burst of writes; load_coefs drops it at the end
   task automatic write_reg(csr_idx_type idx, logic [63:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (idx)
         CSR_KERNEL0: coef_k0   = value;
         CSR_KERNEL1: coef_k1   = value;
         CSR_LAST:    coef_last = value[15:0];
         CSR_BIAS0:   coef_b0   = value[15:0];
         CSR_BIAS1:   coef_b1   = value[15:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pooled_expect.size() != 0) @(negedge clock);
      // back end may still run a row pass on a row that emits nothing
      repeat (2 * IMAGE_SIZE + 20) @(negedge clock);
   endtask

   task automatic load_coefs(logic [63:0] k0, logic [63:0] k1, logic [15:0] lt,
                             logic [15:0] b0, logic [15:0] b1);
      wait_drained();
      write_reg(CSR_KERNEL0, k0);
      write_reg(CSR_KERNEL1, k1);
      write_reg(CSR_LAST, {48'd0, lt});
      write_reg(CSR_BIAS0, {48'd0, b0});
      write_reg(CSR_BIAS1, {48'd0, b1});
      csr_chan.valid <= 1'b0;
   endtask

   // Send count pixel words, continuing the raster position of the stream.
   task automatic send_words(pattern_type kind, logic [PIX_W-1:0] flat, int count);
      logic [PIX_W-1:0] p;
      for (int i = 0; i < count; i++) begin
         case (kind)
            PAT_FLAT:    p = flat;
            PAT_CHECKER: p = ((cur_col ^ cur_row) & 1) ? 8'hff : 8'h00;
            default:     p = PIX_W'($urandom_range(255));
         endcase
         send_pixel(p);
      end
      req_chan.valid <= 1'b0;
   endtask

   // Result check, sampled at the rising edge.
   always @(posedge clock) begin
      pooled_word_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.feature_a, rsp_chan.feature_b, rsp_chan.pooled_row,
                rsp_chan.pooled_col, rsp_chan.row_end, rsp_chan.image_end};
         if (pooled_expect.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, got);
            error_count++;
         end else begin
            want = pooled_expect.pop_front();
            words_checked++;
            if (got !== want) begin
               $display("%0t: mismatch expected a=%0d b=%0d r=%0d c=%0d re=%b ie=%b",
                        $time, want.feature_a, want.feature_b, want.pooled_row,
                        want.pooled_col, want.row_end, want.image_end);
               $display("%0t:          actual   a=%0d b=%0d r=%0d c=%0d re=%b ie=%b",
                        $time, got.feature_a, got.feature_b, got.pooled_row,
                        got.pooled_col, got.row_end, got.image_end);
               error_count++;
            end
         end
      end
   end

   // Receiver stall, changed at the falling edge.
   always @(negedge clock)
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);

   // Watchdog on cycles with no accepted word on any of the three channels.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic test_reset_coefs();
      // zero coefficients: conv row 0 is all zero; two rows emit no pooled word yet
      send_words(PAT_FLAT, 8'd77, DIRECTED_WORDS);
   endtask

   task automatic test_directed_extremes();
      // max positive and max negative kernels and bias on a checkerboard,
      // then mixed kernels on flat 255 rows
      load_coefs(64'h7f7f7f7f7f7f7f7f, 64'h8080808080808080, 16'h807f,
                 16'h7fff, 16'h8000);
      send_words(PAT_CHECKER, 8'd0, DIRECTED_WORDS);
      load_coefs(64'h0000000000000100, 64'hff01ff01ff01ff01, 16'h01ff,
                 16'h0000, 16'h0010);
      send_words(PAT_FLAT, 8'd255, DIRECTED_WORDS);
      wait_drained();
   endtask

   task automatic test_random_words(int n);
      load_coefs({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                 16'($urandom_range(600)) - 16'd300, 16'($urandom));
      send_words(PAT_RANDOM, 8'd0, n);
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.pixel = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_KERNEL0;
      csr_chan.data  = '0;
      rsp_chan.ready = 1'b1;
      coef_k0 = '0; coef_k1 = '0; coef_last = '0; coef_b0 = '0; coef_b1 = '0;
      cur_row = 0;
      cur_col = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_coefs();
      test_directed_extremes();
      // idling phases: none, sender, receiver, both
      send_idle_pct = 0;  recv_stall_pct = 0;  test_random_words(RANDOM_WORDS);
      send_idle_pct = 51; recv_stall_pct = 0;  test_random_words(RANDOM_WORDS);
      // pressure: sender waits until every pooled word is back
      wait_drained();
      send_idle_pct = 0;  recv_stall_pct = 51; test_random_words(RANDOM_WORDS);
      send_idle_pct = 22; recv_stall_pct = 22; test_random_words(RANDOM_WORDS);
      send_idle_pct = 0;  recv_stall_pct = 0;
      wait_drained();

      $display("covered %0d image rows, %0d pixel words in, %0d pooled words checked",
               rows_done, words_sent, words_checked);
      $display("coefficient sets include zero, max positive and max negative");
      if (error_count == 0 && pooled_expect.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule
